>>> rtl/dwsd_pkg.sv
package dwsd_pkg;

  // Readout word width
  localparam int unsigned DATA_WORD_BITS = 16;

  // Header counter store
  localparam int unsigned NUM_COUNTERS = 9;
  localparam int unsigned CNT_ADDR_W   = $clog2(NUM_COUNTERS);
  localparam int unsigned CNT_W        = 32;

  // Timestamp
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned HIGH_W  = 32;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_DATA_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_WORD_LIMIT = 1'd1;
  localparam logic [15:0] LIMIT_RESET = 16'd64000;

  // Header codes
  localparam logic [15:0] CODE_DATA_HDR  = 16'h8001;
  localparam logic [15:0] CODE_EXT_TRIG  = 16'h8002;
  localparam logic [15:0] CODE_DATA_EXT  = 16'h8003;
  localparam logic [15:0] CODE_INT_TRIG  = 16'h8004;
  localparam logic [15:0] CODE_RESET     = 16'h8008;
  localparam logic [15:0] CODE_CAL       = 16'h8010;
  localparam logic [15:0] CODE_TBM_RESET = 16'h8020;
  localparam logic [15:0] CODE_INFO      = 16'h8040;
  localparam logic [15:0] CODE_OVERFLOW  = 16'h8080;
  localparam logic [15:0] CODE_DATA_VAR  = 16'h8081;

  typedef enum logic [3:0] {
    K_DATA_HDR  = 4'd0,
    K_EXT_TRIG  = 4'd1,
    K_INT_TRIG  = 4'd2,
    K_RESET     = 4'd3,
    K_CAL       = 4'd4,
    K_TBM_RESET = 4'd5,
    K_DATA_EXT  = 4'd6,
    K_INFO      = 4'd7,
    K_OVERFLOW  = 4'd8,
    K_UNKNOWN   = 4'd9,
    K_DATA_VAR  = 4'd10,
    K_STAMP     = 4'd11,
    K_DATA_KEPT = 4'd12,
    K_DATA_DROP = 4'd13
  } word_kind_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_STAMP  = 3'b010,
    PH_DATA   = 3'b100
  } phase_e;

  // Result fields except the counter value
  typedef struct packed {
    word_kind_e           word_kind;
    logic [11:0]          data_value;
    logic [15:0]          data_index;
    logic                 time_valid;
    logic [STAMP_W-1:0]   time_stamp;
    logic [STAMP_W-1:0]   time_delta;
    logic                 run_closed;
    logic [15:0]          run_length;
    logic                 truncated;
  } result_t;

  function automatic word_kind_e classify(input logic [15:0] w);
    word_kind_e k;
    case (w)
      CODE_DATA_HDR:  k = K_DATA_HDR;
      CODE_EXT_TRIG:  k = K_EXT_TRIG;
      CODE_INT_TRIG:  k = K_INT_TRIG;
      CODE_RESET:     k = K_RESET;
      CODE_CAL:       k = K_CAL;
      CODE_TBM_RESET: k = K_TBM_RESET;
      CODE_DATA_EXT:  k = K_DATA_EXT;
      CODE_INFO:      k = K_INFO;
      CODE_OVERFLOW:  k = K_OVERFLOW;
      CODE_DATA_VAR:  k = K_DATA_VAR;
      default:        k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/daq_word_stream_deframer.sv
// Readout word stream deframer.
// Input channel (in_valid_i/in_ready_o) takes one 16-bit readout word per item
// with an end-of-buffer flag. Output channel (out_valid_o/out_ready_i) gives
// one result item per input item, in order: word kind, updated header count,
// masked data value and index, assembled timestamp and delta, run close
// information and a truncation flag.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the data width mode
// (index 0) or the per-run data word limit (index 1); always ready, and only
// to be used while no item is in flight.
// An accepted item passes through stage 1 and then the output register, where
// out_valid_o rises. Throughput is one item per cycle while the receiver does
// not stall: the header counters sit in a 9-entry synchronous memory, read at
// accept and written back when the item leaves stage 1, with a bypass for a
// counter hit by two items in a row.
// Reset clears all parse state, the counters (through per-entry valid bits)
// and restores the configuration defaults; no clearing pass is needed.
// When the receiver stalls, the output register and the one stage behind it
// fill, then in_ready_o drops; no item is lost or repeated.
module daq_word_stream_deframer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dwsd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dwsd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dwsd_pkg::DATA_WORD_BITS-1:0]  stream_word_i,
  input  logic                                 end_of_buffer_i,
  // Result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [3:0]                           word_kind_o,
  output logic [dwsd_pkg::CNT_W-1:0]           kind_count_o,
  output logic [11:0]                          data_value_o,
  output logic [15:0]                          data_index_o,
  output logic                                 time_valid_o,
  output logic [dwsd_pkg::STAMP_W-1:0]         time_stamp_o,
  output logic [dwsd_pkg::STAMP_W-1:0]         time_delta_o,
  output logic                                 run_closed_o,
  output logic [15:0]                          run_length_o,
  output logic                                 truncated_o
);
  import dwsd_pkg::*;

  // Configuration registers
  logic        wide_mode_q;
  logic [15:0] limit_q;

  // Parse state
  phase_e              phase_q, phase_d;
  logic [1:0]          seen_q, seen_d;
  logic [HIGH_W-1:0]   high_q, high_d;
  logic                frame_data_q, frame_data_d;
  logic [15:0]         dcount_q, dcount_d;
  logic [STAMP_W-1:0]  prev_time_q, prev_time_d;

  // Pipeline stage and output register
  logic                   s1_valid_q;
  logic                   s1_counted_q;
  logic [CNT_ADDR_W-1:0]  s1_addr_q;
  result_t                s1_res_q;
  logic                   out_valid_q;
  result_t                out_res_q;
  logic [CNT_W-1:0]       out_count_q;

  // Counter memory
  logic [CNT_W-1:0]       cnt_mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] cnt_vld_q;
  logic [CNT_W-1:0]       rd_data_q;
  logic                   rd_vld_q;
  logic [CNT_ADDR_W-1:0]  rd_addr;
  logic                   fwd_valid_q;
  logic [CNT_ADDR_W-1:0]  fwd_addr_q;
  logic [CNT_W-1:0]       fwd_data_q;

  logic       accept;
  logic       s1_adv;
  logic       cnt_wr;
  logic [CNT_W-1:0] cnt_old;
  logic [CNT_W-1:0] cnt_new;

  // Stage 0 results
  result_t              res;
  logic                 counted;
  logic [CNT_ADDR_W-1:0] new_addr;
  logic                 as_header;
  word_kind_e           hdr_kind;
  logic [STAMP_W-1:0]   stamp_full;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b1;
      limit_q     <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDE_DATA_MODE:  wide_mode_q <= cfg_data_i[0];
        REG_DATA_WORD_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Word decode and parse state update
  always_comb begin
    res          = '0;
    res.word_kind = K_UNKNOWN;
    counted      = 1'b0;
    as_header    = 1'b0;
    phase_d      = phase_q;
    seen_d       = seen_q;
    high_d       = high_q;
    frame_data_d = frame_data_q;
    dcount_d     = dcount_q;
    prev_time_d  = prev_time_q;
    hdr_kind     = classify(stream_word_i);
    stamp_full   = {high_q, stream_word_i};

    case (phase_q)
      PH_DATA: begin
        if (stream_word_i == CODE_RESET || stream_word_i == CODE_INT_TRIG) begin
          res.run_closed = 1'b1;
          res.run_length = dcount_q;
          dcount_d       = '0;
          as_header      = 1'b1;
        end else begin
          if (dcount_q < limit_q) begin
            res.word_kind  = K_DATA_KEPT;
            res.data_value = wide_mode_q ? stream_word_i[11:0]
                                         : {8'h00, stream_word_i[3:0]};
            res.data_index = dcount_q;
            dcount_d       = dcount_q + 16'd1;
          end else begin
            res.word_kind = K_DATA_DROP;
          end
          if (end_of_buffer_i) begin
            res.run_closed = 1'b1;
            res.run_length = dcount_d;
          end
        end
      end
      PH_STAMP: begin
        res.word_kind = K_STAMP;
        if (seen_q < 2'd2) begin
          high_d = {high_q[HIGH_W-17:0], stream_word_i};
          seen_d = seen_q + 2'd1;
          res.truncated = end_of_buffer_i;
        end else begin
          res.time_valid = 1'b1;
          res.time_stamp = stamp_full;
          res.time_delta = stamp_full - prev_time_q;
          prev_time_d    = stamp_full;
          seen_d         = '0;
          high_d         = '0;
          dcount_d       = '0;
          if (frame_data_q) begin
            phase_d = PH_DATA;
            res.run_closed = end_of_buffer_i;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      end
      default: begin
        as_header = 1'b1;
      end
    endcase

    // Header classification, also for run terminators
    if (as_header) begin
      res.word_kind = hdr_kind;
      counted = (hdr_kind != K_UNKNOWN) && (hdr_kind != K_DATA_VAR);
      if (hdr_kind != K_UNKNOWN && hdr_kind != K_INFO && hdr_kind != K_OVERFLOW) begin
        phase_d       = PH_STAMP;
        seen_d        = '0;
        high_d        = '0;
        frame_data_d  = (hdr_kind == K_DATA_HDR) || (hdr_kind == K_DATA_VAR);
        res.truncated = end_of_buffer_i;
      end else begin
        phase_d = PH_HEADER;
      end
    end

    // Buffer end drops any partial frame
    if (end_of_buffer_i) begin
      phase_d      = PH_HEADER;
      seen_d       = '0;
      high_d       = '0;
      frame_data_d = 1'b0;
      dcount_d     = '0;
    end
  end

  assign new_addr = counted ? hdr_kind[CNT_ADDR_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      seen_q       <= '0;
      high_q       <= '0;
      frame_data_q <= 1'b0;
      dcount_q     <= '0;
      prev_time_q  <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      seen_q       <= seen_d;
      high_q       <= high_d;
      frame_data_q <= frame_data_d;
      dcount_q     <= dcount_d;
      prev_time_q  <= prev_time_d;
    end
  end

  // Stage 1: counter read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_counted_q <= counted;
      s1_addr_q    <= new_addr;
      s1_res_q     <= res;
    end
  end

  // Read address: new item, or re-read while the stage is held
  assign rd_addr = accept ? new_addr : s1_addr_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= cnt_mem[rd_addr];
    if (cnt_wr) begin
      cnt_mem[s1_addr_q] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cnt_vld_q[rd_addr];
      if (cnt_wr) begin
        cnt_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // Increment with bypass of last cycle's write
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == s1_addr_q) begin
      cnt_old = fwd_data_q;
    end else if (rd_vld_q) begin
      cnt_old = rd_data_q;
    end else begin
      cnt_old = '0;
    end
    cnt_new = cnt_old + 32'd1;
  end

  assign cnt_wr = s1_adv && s1_counted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= cnt_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= cnt_new;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q   <= s1_res_q;
      out_count_q <= s1_counted_q ? cnt_new : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_kind_o  = out_res_q.word_kind;
  assign kind_count_o = out_count_q;
  assign data_value_o = out_res_q.data_value;
  assign data_index_o = out_res_q.data_index;
  assign time_valid_o = out_res_q.time_valid;
  assign time_stamp_o = out_res_q.time_stamp;
  assign time_delta_o = out_res_q.time_delta;
  assign run_closed_o = out_res_q.run_closed;
  assign run_length_o = out_res_q.run_length;
  assign truncated_o  = out_res_q.truncated;

endmodule
